FILE: hw/rtl/mpfbc_pkg.sv
`default_nettype none
package mpfbc_pkg;

  localparam int SHARES = 32;
  localparam int STEPS = 16;
  localparam int FEISTEL_ROUNDS = 4;
  localparam int SIW = $clog2(SHARES);
  localparam int SW = $clog2(STEPS + 1);
  localparam int RW = (FEISTEL_ROUNDS > 1) ? $clog2(FEISTEL_ROUNDS) : 1;

  localparam logic [31:0] PMASK = 32'h7FFF_FFFF;
  localparam logic [31:0] MASK_RAND = 32'h618d_de64;
  localparam logic [63:0] PI_INIT = 64'hC90F_DAA2_2168_C234;

  localparam logic [1:0] CMD_TEXT = 2'd0;
  localparam logic [1:0] CMD_KEY = 2'd1;
  localparam logic [1:0] CMD_TWEAK = 2'd2;
  localparam logic [1:0] CMD_RUN = 2'd3;

  localparam logic [3:0] OP_NONE = 4'd0;
  localparam logic [3:0] OP_LOAD = 4'd1;
  localparam logic [3:0] OP_TWK_INIT = 4'd2;
  localparam logic [3:0] OP_TWK_ITER = 4'd3;
  localparam logic [3:0] OP_COPY = 4'd4;
  localparam logic [3:0] OP_TKY = 4'd5;
  localparam logic [3:0] OP_RC = 4'd6;
  localparam logic [3:0] OP_PREP = 4'd7;
  localparam logic [3:0] OP_SQ_INIT = 4'd8;
  localparam logic [3:0] OP_SQ_MUL = 4'd9;
  localparam logic [3:0] OP_SQ_ACC = 4'd10;
  localparam logic [3:0] OP_SQ_FMUL = 4'd11;
  localparam logic [3:0] OP_SQ_FIN = 4'd12;
  localparam logic [3:0] OP_MIX1 = 4'd13;
  localparam logic [3:0] OP_MIX2 = 4'd14;
  localparam logic [3:0] OP_OUT = 4'd15;

  typedef struct packed {
    logic [1:0] cmd;
    logic [4:0] share_index;
    logic [31:0] lane0_word;
    logic [31:0] lane1_word;
    logic [31:0] lane2_word;
    logic [31:0] lane3_word;
  } in_item_t;

  typedef struct packed {
    logic [4:0] out_share_index;
    logic [31:0] out_lane0;
    logic [31:0] out_lane1;
    logic [31:0] out_lane2;
    logic [31:0] out_lane3;
    logic out_last;
  } out_item_t;

  typedef struct packed {
    logic [3:0] op;
    logic [SIW-1:0] i;
    logic [SIW-1:0] j;
    logic [SW-1:0] row;
    logic sel;
    logic inv;
    logic last_k;
  } dp_cmd_t;

  function automatic logic [31:0] madd(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] s;
    s = a + b;
    return {1'b0, s[30:0]} + {31'b0, s[31]};
  endfunction

  function automatic logic [31:0] msub(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] x;
    x = a - b;
    return {1'b0, x[30:0]} - {31'b0, x[31]};
  endfunction

  function automatic logic [31:0] rot_left(input logic [31:0] a);
    logic [31:0] s;
    s = {a[30:0], 1'b0} + {30'b0, a[31:30]};
    return s & PMASK;
  endfunction

  function automatic logic [31:0] psi(input logic [31:0] a);
    return a ^ {1'b0, a[31:1]} ^ {1'b0, PMASK[31:1]};
  endfunction

  function automatic logic [31:0] fold2(input logic [63:0] x);
    logic [33:0] y;
    logic [33:0] z;
    y = {3'b0, x[30:0]} + {1'b0, x[63:31]};
    z = {3'b0, y[30:0]} + {31'b0, y[33:31]};
    return z[31:0];
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/mpfbc_ctrl.sv
`default_nettype none
module mpfbc_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic              cfg_wdata,
  input  wire logic              in_valid,
  input  wire logic [1:0]        in_cmd,
  output logic                   in_stall,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output mpfbc_pkg::dp_cmd_t     dp_cmd
);
  import mpfbc_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_TWI = 4'd1;
  localparam logic [3:0] S_TWK = 4'd2;
  localparam logic [3:0] S_COPY = 4'd3;
  localparam logic [3:0] S_TKY = 4'd4;
  localparam logic [3:0] S_RCS = 4'd5;
  localparam logic [3:0] S_PREP = 4'd6;
  localparam logic [3:0] S_SQI = 4'd7;
  localparam logic [3:0] S_SQM = 4'd8;
  localparam logic [3:0] S_SQA = 4'd9;
  localparam logic [3:0] S_SQF = 4'd10;
  localparam logic [3:0] S_SQN = 4'd11;
  localparam logic [3:0] S_MIX1 = 4'd12;
  localparam logic [3:0] S_MIX2 = 4'd13;
  localparam logic [3:0] S_OUT = 4'd14;
  localparam logic [3:0] S_DRAIN = 4'd15;

  localparam logic [SIW-1:0] ILAST = SIW'(SHARES - 1);

  logic [3:0] state_r, state_nxt;
  logic [SIW-1:0] i_r, i_nxt, j_r, j_nxt;
  logic [SW-1:0] s_r, s_nxt;
  logic [RW-1:0] rnd_r, rnd_nxt;
  logic [1:0] k_r, k_nxt;
  logic sel_r, sel_nxt;
  logic dir_r;
  logic ov_r, ov_nxt;

  assign in_stall = (state_r != S_IDLE);
  assign out_valid = ov_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      i_r <= '0;
      j_r <= '0;
      s_r <= '0;
      rnd_r <= '0;
      k_r <= '0;
      sel_r <= 1'b0;
      dir_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      i_r <= i_nxt;
      j_r <= j_nxt;
      s_r <= s_nxt;
      rnd_r <= rnd_nxt;
      k_r <= k_nxt;
      sel_r <= sel_nxt;
      ov_r <= ov_nxt;
      if (cfg_we) begin
        dir_r <= cfg_wdata;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    i_nxt = i_r;
    j_nxt = j_r;
    s_nxt = s_r;
    rnd_nxt = rnd_r;
    k_nxt = k_r;
    sel_nxt = sel_r;
    ov_nxt = ov_r;
    dp_cmd.op = OP_NONE;
    dp_cmd.i = i_r;
    dp_cmd.j = j_r;
    dp_cmd.row = dir_r ? SW'(STEPS) - s_r : s_r;
    dp_cmd.sel = sel_r;
    dp_cmd.inv = dir_r;
    dp_cmd.last_k = (k_r == 2'd3);
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_cmd == CMD_RUN) begin
            state_nxt = S_TWI;
          end else begin
            dp_cmd.op = OP_LOAD;
          end
        end
      end
      S_TWI: begin
        dp_cmd.op = OP_TWK_INIT;
        s_nxt = '0;
        k_nxt = '0;
        state_nxt = S_TWK;
      end
      S_TWK: begin
        dp_cmd.op = OP_TWK_ITER;
        dp_cmd.row = s_r + SW'(1);
        if (k_r == 2'd3) begin
          k_nxt = '0;
          if (s_r == SW'(STEPS - 1)) begin
            s_nxt = '0;
            i_nxt = '0;
            state_nxt = S_COPY;
          end else begin
            s_nxt = s_r + SW'(1);
          end
        end else begin
          k_nxt = k_r + 2'd1;
        end
      end
      S_COPY: begin
        dp_cmd.op = OP_COPY;
        if (i_r == ILAST) begin
          i_nxt = '0;
          state_nxt = S_TKY;
        end else begin
          i_nxt = i_r + SIW'(1);
        end
      end
      S_TKY: begin
        dp_cmd.op = OP_TKY;
        if (i_r == ILAST) begin
          i_nxt = '0;
          rnd_nxt = '0;
          state_nxt = (s_r == SW'(STEPS)) ? S_OUT : S_RCS;
        end else begin
          i_nxt = i_r + SIW'(1);
        end
      end
      S_RCS: begin
        dp_cmd.op = OP_RC;
        i_nxt = '0;
        state_nxt = S_PREP;
      end
      S_PREP: begin
        dp_cmd.op = OP_PREP;
        if (i_r == ILAST) begin
          i_nxt = '0;
          sel_nxt = 1'b0;
          state_nxt = S_SQI;
        end else begin
          i_nxt = i_r + SIW'(1);
        end
      end
      S_SQI: begin
        dp_cmd.op = OP_SQ_INIT;
        if (i_r == ILAST) begin
          state_nxt = S_SQF;
        end else begin
          j_nxt = i_r + SIW'(1);
          state_nxt = S_SQM;
        end
      end
      S_SQM: begin
        dp_cmd.op = OP_SQ_MUL;
        state_nxt = S_SQA;
      end
      S_SQA: begin
        dp_cmd.op = OP_SQ_ACC;
        if (j_r == ILAST) begin
          state_nxt = S_SQF;
        end else begin
          j_nxt = j_r + SIW'(1);
          state_nxt = S_SQM;
        end
      end
      S_SQF: begin
        dp_cmd.op = OP_SQ_FMUL;
        state_nxt = S_SQN;
      end
      S_SQN: begin
        dp_cmd.op = OP_SQ_FIN;
        if (i_r == ILAST) begin
          i_nxt = '0;
          state_nxt = sel_r ? S_MIX2 : S_MIX1;
        end else begin
          i_nxt = i_r + SIW'(1);
          state_nxt = S_SQI;
        end
      end
      S_MIX1: begin
        dp_cmd.op = OP_MIX1;
        if (i_r == ILAST) begin
          i_nxt = '0;
          sel_nxt = 1'b1;
          state_nxt = S_SQI;
        end else begin
          i_nxt = i_r + SIW'(1);
        end
      end
      S_MIX2: begin
        dp_cmd.op = OP_MIX2;
        if (i_r == ILAST) begin
          i_nxt = '0;
          if (rnd_r == RW'(FEISTEL_ROUNDS - 1)) begin
            s_nxt = s_r + SW'(1);
            state_nxt = S_TKY;
          end else begin
            rnd_nxt = rnd_r + RW'(1);
            state_nxt = S_RCS;
          end
        end else begin
          i_nxt = i_r + SIW'(1);
        end
      end
      S_OUT: begin
        if (!ov_r || !out_stall) begin
          dp_cmd.op = OP_OUT;
          ov_nxt = 1'b1;
          if (i_r == ILAST) begin
            i_nxt = '0;
            state_nxt = S_DRAIN;
          end else begin
            i_nxt = i_r + SIW'(1);
          end
        end
      end
      S_DRAIN: begin
        if (!out_stall) begin
          ov_nxt = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: hw/rtl/mpfbc_dp.sv
`default_nettype none
module mpfbc_dp (
  input  wire logic                 clk,
  input  wire mpfbc_pkg::in_item_t  in_data,
  input  wire mpfbc_pkg::dp_cmd_t   dp_cmd,
  output mpfbc_pkg::out_item_t      out_data
);
  import mpfbc_pkg::*;

  logic [31:0] text_r [4][SHARES];
  logic [31:0] key_r [4][SHARES];
  logic [31:0] work_r [4][SHARES];
  logic [31:0] tweak_r [4];
  logic [31:0] trt_r [STEPS+1][4];
  logic [31:0] tw_r [4];
  logic [31:0] s_r [SHARES];
  logic [31:0] f_r [SHARES];
  logic [31:0] m_r [SHARES];
  logic [31:0] d_r [SHARES];
  logic [63:0] rc_r;
  logic [63:0] pc_r;
  logic [63:0] prod_r;
  logic [31:0] acc_r;
  logic [31:0] g_r;
  logic [31:0] keep_r;
  out_item_t out_r;

  logic [31:0] lane_w [4];
  logic [31:0] q [4];
  logic [31:0] tn [4];
  logic [1:0] bx, by, bu, bv;
  logic [31:0] src_i, src_j;
  logic [31:0] mi, fa, ma, fb;
  logic [SIW-1:0] ix, jx;
  logic [63:0] rc_rr;

  assign ix = dp_cmd.i;
  assign jx = dp_cmd.j;
  assign out_data = out_r;
  assign lane_w[0] = in_data.lane0_word;
  assign lane_w[1] = in_data.lane1_word;
  assign lane_w[2] = in_data.lane2_word;
  assign lane_w[3] = in_data.lane3_word;
  assign rc_rr = {rc_r[0], rc_r[63:1]};

  always_comb begin
    bx = dp_cmd.inv ? 2'd3 : 2'd1;
    by = dp_cmd.inv ? 2'd2 : 2'd0;
    bu = dp_cmd.inv ? 2'd0 : 2'd2;
    bv = dp_cmd.inv ? 2'd1 : 2'd3;
    src_i = dp_cmd.sel ? f_r[ix] : s_r[ix];
    src_j = dp_cmd.sel ? f_r[jx] : s_r[jx];
    for (int b = 0; b < 4; b++) begin
      q[b] = psi(tw_r[b]);
    end
    tn[1] = madd(q[0], q[3]);
    tn[0] = madd(q[0], tn[1]);
    tn[3] = madd(q[2], q[1]);
    tn[2] = madd(q[2], tn[3]);
    mi = madd(d_r[ix], work_r[by][ix]);
    fa = madd(s_r[ix], mi);
    ma = madd(fa, mi);
    fb = madd(d_r[ix], m_r[ix]);
  end

  always_ff @(posedge clk) begin
    case (dp_cmd.op)
      OP_LOAD: begin
        if (in_data.cmd == CMD_TWEAK) begin
          for (int b = 0; b < 4; b++) tweak_r[b] <= lane_w[b];
        end else if (32'(in_data.share_index) < SHARES) begin
          for (int b = 0; b < 4; b++) begin
            if (in_data.cmd == CMD_TEXT) begin
              text_r[b][SIW'(in_data.share_index)] <= lane_w[b];
            end else if (in_data.cmd == CMD_KEY) begin
              key_r[b][SIW'(in_data.share_index)] <= lane_w[b];
            end
          end
        end
      end
      OP_TWK_INIT: begin
        for (int b = 0; b < 4; b++) begin
          trt_r[0][b] <= tweak_r[b];
          tw_r[b] <= tweak_r[b];
        end
        rc_r <= PI_INIT;
      end
      OP_TWK_ITER: begin
        for (int b = 0; b < 4; b++) begin
          tw_r[b] <= tn[b];
          if (dp_cmd.last_k) trt_r[dp_cmd.row][b] <= tn[b];
        end
      end
      OP_COPY: begin
        for (int b = 0; b < 4; b++) work_r[b][ix] <= text_r[b][ix];
      end
      OP_TKY: begin
        for (int b = 0; b < 4; b++) begin
          logic [31:0] k;
          k = (ix == '0) ? madd(trt_r[dp_cmd.row][b], key_r[b][0]) : key_r[b][ix];
          work_r[b][ix] <= dp_cmd.inv ? msub(work_r[b][ix], k) : madd(work_r[b][ix], k);
        end
      end
      OP_RC: begin
        if (dp_cmd.inv) begin
          rc_r <= rc_rr;
          pc_r <= rc_rr;
        end else begin
          pc_r <= rc_r;
          rc_r <= {rc_r[62:0], rc_r[63]};
        end
      end
      OP_PREP: begin
        if (ix == '0) begin
          keep_r <= work_r[bx][0];
          s_r[ix] <= madd(work_r[bx][0], {1'b0, pc_r[30:0]});
        end else begin
          s_r[ix] <= work_r[bx][ix];
        end
      end
      OP_SQ_INIT: begin
        acc_r <= (ix == '0) ? 32'd0 : d_r[ix];
        g_r <= src_i;
      end
      OP_SQ_MUL: begin
        prod_r <= 64'(rot_left(src_j) + MASK_RAND) * 64'(src_i);
      end
      OP_SQ_ACC: begin
        acc_r <= fold2(prod_r + 64'(MASK_RAND) + 64'(acc_r));
        d_r[jx] <= (ix == '0) ? (PMASK - MASK_RAND) : msub(d_r[jx], MASK_RAND);
        g_r <= msub(g_r, MASK_RAND);
      end
      OP_SQ_FMUL: begin
        prod_r <= 64'(src_i) * 64'(g_r);
      end
      OP_SQ_FIN: begin
        d_r[ix] <= fold2(prod_r + 64'(acc_r));
      end
      OP_MIX1: begin
        f_r[ix] <= (ix == '0) ? madd(fa, {1'b0, pc_r[62:32]}) : fa;
        m_r[ix] <= ma;
      end
      OP_MIX2: begin
        work_r[bv][ix] <= (ix == '0) ? keep_r : s_r[ix];
        work_r[bu][ix] <= work_r[by][ix];
        work_r[by][ix] <= dp_cmd.inv ? msub(work_r[bu][ix], f_r[ix])
                                     : madd(work_r[bu][ix], f_r[ix]);
        work_r[bx][ix] <= dp_cmd.inv ? msub(work_r[bv][ix], fb)
                                     : madd(work_r[bv][ix], fb);
      end
      OP_OUT: begin
        out_r.out_share_index <= 5'(ix);
        out_r.out_lane0 <= work_r[0][ix];
        out_r.out_lane1 <= work_r[1][ix];
        out_r.out_lane2 <= work_r[2][ix];
        out_r.out_lane3 <= work_r[3][ix];
        out_r.out_last <= (ix == SIW'(SHARES - 1));
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: hw/rtl/masked_prime_field_block_cipher_top.sv
// Masked tweakable block cipher over the prime 2^31-1, 32 shares per branch.
// Input channel (in_valid / in_stall / in_data): load items write one text or
// key share row, or the four tweak words, and are taken while idle. A run
// item starts the cipher; in_stall stays high until its last row is taken.
// Configuration: cfg_we / cfg_wdata write the direction bit (0 encrypt,
// 1 decrypt); write it only while no run is in progress.
// A run's computation centres on the shared squaring and its 32x32
// multiplies (a multiply and an accumulate state per step, 128 squarings
// of 496 steps each); then the 32 result rows leave one per cycle while
// out_stall is low, on out_valid / out_stall / out_data, out_last marking the last row.
// A stalled receiver holds the current row in the output register and pauses
// the row sequence; nothing is lost.
// Reset clears the controller and direction; share, key and tweak stores keep
// no reset value and must be loaded before a run.
`default_nettype none
module masked_prime_field_block_cipher_top (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic                 cfg_wdata,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire mpfbc_pkg::in_item_t  in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output mpfbc_pkg::out_item_t      out_data
);
  import mpfbc_pkg::*;

  dp_cmd_t dp_cmd;

  mpfbc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_cmd    (in_data.cmd),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .dp_cmd    (dp_cmd)
  );

  mpfbc_dp u_dp (
    .clk      (clk),
    .in_data  (in_data),
    .dp_cmd   (dp_cmd),
    .out_data (out_data)
  );

endmodule
`default_nettype wire

FILE: hw/rtl/mpfbc_checker.sv
`default_nettype none
module mpfbc_checker (
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 in_valid,
  input wire logic                 in_stall,
  input wire mpfbc_pkg::in_item_t  in_data,
  input wire logic                 out_valid,
  input wire logic                 out_stall,
  input wire mpfbc_pkg::out_item_t out_data
);
  import mpfbc_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("output item changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("block not idle after reset");

  a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.cmd == CMD_RUN |=> in_stall && !out_valid)
    else $error("run item did not start work");

  a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_data.out_last |=> !out_valid && !in_stall)
    else $error("block not idle after last row");

  a_no_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("result item while input open");

endmodule

bind masked_prime_field_block_cipher_top mpfbc_checker u_mpfbc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
`default_nettype wire
